@@ rtl/core/utrd_pkg.sv @@
// Package for the unsigned-to-radix-digits converter.
// Holds the request and digit payload types, field widths, default sizes
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package utrd_pkg;

  localparam int VALUE_W      = 64;
  localparam int RADIX_W      = 6;
  localparam int CHAR_W       = 8;
  localparam int COUNT_W      = 7;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL_BASE = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'h30;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [CHAR_W-1:0]  letter_start;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
    logic [COUNT_W-1:0] digit_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic store_full;
    logic rd_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/unsigned_to_radix_digits.sv @@
// Top level of the unsigned-to-radix-digits converter.
// Instantiates utrd_ctrl and utrd_datapath; uses utrd_pkg types.
//
// Request channel (item_valid/item_ready/item): one value, a radix (clamped
// to 2..36) and the character code for digit ten. Digit channel
// (digit_valid/digit_ready/digit): one character per digit, most
// significant first, with last on the final digit and the digit count.
// A zero value yields the single digit '0'. Values needing more than
// MAX_DIGITS digits give only the low MAX_DIGITS digits.
// Each digit is produced by the shared restoring divider (one quotient bit
// per cycle) followed by a store step, then readout from the digit store goes
// through its registered read port and then the output register, digit by digit.
// The next request is taken once the final digit of the previous one has
// been loaded into the output register.
// Reset (rst, synchronous) returns the controller to idle and drops any
// pending digit. When the receiver stalls, the digit is held in the output
// register and readout pauses; a new request is still taken while the
// final digit waits.
`default_nettype none

module unsigned_to_radix_digits #(
  parameter int VALUE_BITS = utrd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = utrd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire utrd_pkg::in_t  item,
  output logic                digit_valid,
  input  wire logic           digit_ready,
  output utrd_pkg::out_t      digit
);
  import utrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  utrd_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .digit_valid(digit_valid),
    .digit_ready(digit_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  utrd_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk  (clk),
    .item (item),
    .cmd  (cmd),
    .sts  (sts),
    .digit(digit)
  );

endmodule

`default_nettype wire

@@ rtl/core/utrd_datapath.sv @@
// Datapath of the radix converter: restoring bit-serial divider, digit
// store memory, read pointer and output payload register.
// Depends on utrd_pkg for payload types and command/status structs.
`default_nettype none

module utrd_datapath #(
  parameter int VALUE_BITS = utrd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = utrd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic          clk,
  input  wire utrd_pkg::in_t item,
  input  wire utrd_pkg::cmd_t cmd,
  output utrd_pkg::sts_t     sts,
  output utrd_pkg::out_t     digit
);
  import utrd_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] c;
    c = r;
    if (r < RADIX_MIN) c = RADIX_MIN;
    if (r > RADIX_MAX) c = RADIX_MAX;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d,
                                                      input logic [CHAR_W-1:0] letter);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < DECIMAL_BASE) return CHAR_ZERO + dx;
    return letter + dx - {{(CHAR_W-RADIX_W){1'b0}}, DECIMAL_BASE};
  endfunction

  logic [VALUE_BITS-1:0] quot;
  logic [RADIX_W-1:0]    rem;
  logic [RADIX_W-1:0]    radix;
  logic [CHAR_W-1:0]     letter;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      rd_ptr;
  logic [RADIX_W-1:0]    rd_data;
  logic                  rd_last;
  logic [RADIX_W-1:0]    digit_store [MAX_DIGITS];

  logic [RADIX_W:0]      rem_sh;
  logic [RADIX_W:0]      rem_diff;
  logic                  q_bit;
  logic [CNT_W-1:0]      cnt_next;

  assign rem_sh   = {rem, quot[VALUE_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, radix};
  assign q_bit    = (rem_sh >= {1'b0, radix});
  assign cnt_next = cnt + CNT_W'(1);

  assign sts.quot_zero  = (quot == '0);
  assign sts.store_full = (cnt_next == CNT_W'(MAX_DIGITS));
  assign sts.rd_last    = rd_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot   <= item.value[VALUE_BITS-1:0];
      rem    <= '0;
      radix  <= clamp_radix(item.radix);
      letter <= item.letter_start;
      cnt    <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[VALUE_BITS-2:0], q_bit};
      rem  <= q_bit ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    end else if (cmd.store) begin
      rem    <= '0;
      cnt    <= cnt_next;
      rd_ptr <= cnt[IDX_W-1:0];
    end else if (cmd.rd) begin
      rd_ptr <= rd_ptr - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_store[cnt[IDX_W-1:0]] <= rem;
    end
    if (cmd.rd) begin
      rd_data <= digit_store[rd_ptr];
      rd_last <= (rd_ptr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digit.digit_char  <= digit_to_char(rd_data, letter);
      digit.last        <= rd_last;
      digit.digit_count <= COUNT_W'(cnt);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utrd_ctrl.sv @@
// Controller of the radix converter: request intake, divide step count,
// digit collection and most-significant-first readout with output valid.
// Depends on utrd_pkg for the command and status structs.
`default_nettype none

module utrd_ctrl #(
  parameter int VALUE_BITS = utrd_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  output logic                digit_valid,
  input  wire logic           digit_ready,
  input  wire utrd_pkg::sts_t sts,
  output utrd_pkg::cmd_t      cmd
);
  import utrd_pkg::*;

  localparam int STEP_W = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    STORE,
    READ,
    LOAD
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic                out_free;

  assign item_ready   = (state == IDLE);
  assign out_free     = !digit_valid || digit_ready;

  assign cmd.load     = (state == IDLE) && item_valid;
  assign cmd.div_step = (state == DIV);
  assign cmd.store    = (state == STORE);
  assign cmd.rd       = (state == READ) && out_free;
  assign cmd.out_load = (state == LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      step        <= '0;
      digit_valid <= 1'b0;
    end else begin
      if (digit_valid && digit_ready) digit_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (item_valid) begin
            step  <= STEP_W'(VALUE_BITS - 1);
            state <= DIV;
          end
        end
        DIV: begin
          if (step == '0) state <= STORE;
          else step <= step - STEP_W'(1);
        end
        STORE: begin
          step <= STEP_W'(VALUE_BITS - 1);
          if (sts.quot_zero || sts.store_full) state <= READ;
          else state <= DIV;
        end
        READ: begin
          if (out_free) state <= LOAD;
        end
        LOAD: begin
          digit_valid <= 1'b1;
          state       <= sts.rd_last ? IDLE : READ;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD) |-> !digit_valid)
    else $error("output register overwritten while holding a digit");

  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state == DIV))
    else $error("accepted request did not start division");

  a_store_done: assert property (@(posedge clk) disable iff (rst)
    (state == STORE && (sts.quot_zero || sts.store_full)) |=> (state == READ))
    else $error("digit collection did not end on zero quotient or full store");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD && sts.rd_last) |=> (state == IDLE && digit_valid))
    else $error("final digit did not return controller to idle");

endmodule

`default_nettype wire

@@ sim/unsigned_to_radix_digits_tb.sv @@
// Testbench for unsigned_to_radix_digits. It predicts the digit characters of each request
// and checks them in order, using directed, paused and random requests with idle bursts.
// Depends on utrd_pkg and the unsigned_to_radix_digits RTL.
`timescale 1ns / 100ps

module unsigned_to_radix_digits_tb;
  import utrd_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS_DEF);
  localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_t item;
  logic digit_valid;
  logic digit_ready;
  out_t digit;

  out_t pending_digits[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit idle_enable = 1'b1;

  unsigned_to_radix_digits #(
    .VALUE_BITS(VALUE_BITS_DEF),
    .MAX_DIGITS(MAX_DIGITS_DEF)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .digit_valid(digit_valid),
    .digit_ready(digit_ready),
    .digit(digit)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void predict_digits(input in_t req);
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] base;
    logic [RADIX_W-1:0] digit_val [MAX_DIGITS_DEF];
    int n;
    out_t res;
    base = VALUE_W'(req.radix);
    if (req.radix < RADIX_MIN) begin
      base = VALUE_W'(RADIX_MIN);
    end else if (req.radix > RADIX_MAX) begin
      base = VALUE_W'(RADIX_MAX);
    end
    quot = req.value & VALUE_MASK;
    n = 0;
    if (quot == '0) begin
      digit_val[0] = '0;
      n = 1;
    end
    while (quot != '0 && n < MAX_DIGITS_DEF) begin
      digit_val[n] = RADIX_W'(quot % base);
      quot = quot / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (digit_val[k] < DECIMAL_BASE) begin
        res.digit_char = CHAR_ZERO + CHAR_W'(digit_val[k]);
      end else begin
        res.digit_char = req.letter_start + CHAR_W'(digit_val[k]) - CHAR_W'(DECIMAL_BASE);
      end
      res.last = (k == 0);
      res.digit_count = COUNT_W'(n);
      pending_digits.push_back(res);
    end
  endfunction

  function automatic in_t make_req(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                                   input logic [CHAR_W-1:0] l);
    in_t req;
    req.value = v;
    req.radix = r;
    req.letter_start = l;
    return req;
  endfunction

  function automatic in_t random_req();
    in_t req;
    int sel;
    int nbits;
    sel = $urandom_range(0, 99);
    req.value = {$urandom, $urandom};
    if (sel < 5) begin
      req.value = '0;
    end else if (sel < 15) begin
      nbits = VALUE_W;
    end else begin
      nbits = $urandom_range(1, 24);
      req.value = req.value & (ALL_ONES >> (VALUE_W - nbits));
    end
    if ($urandom_range(0, 99) < 85) begin
      req.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    end else begin
      req.radix = RADIX_W'($urandom_range(0, 63));
    end
    req.letter_start = CHAR_W'($urandom_range(0, 255));
    return req;
  endfunction

  task automatic send_request(input in_t req);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= req;
    do @(posedge clk); while (!item_ready);
    predict_digits(req);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_digits.size() != 0);
  endtask

  // digit sink with random stall bursts
  initial begin
    digit_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        digit_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      digit_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t exp_digit;
    if (!rst) begin
      if ((item_valid && item_ready) || (digit_valid && digit_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d digits outstanding", $time,
                 pending_digits.size());
        $display("unsigned_to_radix_digits_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (digit_valid && digit_ready) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected digit, expected none, actual char %0d last %0d count %0d",
                   $time, digit.digit_char, digit.last, digit.digit_count);
          error_count++;
        end else begin
          exp_digit = pending_digits.pop_front();
          if (digit.digit_char !== exp_digit.digit_char) begin
            $display("%0t: digit_char mismatch, expected %0d actual %0d", $time,
                     exp_digit.digit_char, digit.digit_char);
            error_count++;
          end
          if (digit.last !== exp_digit.last) begin
            $display("%0t: last mismatch, expected %0d actual %0d", $time,
                     exp_digit.last, digit.last);
            error_count++;
          end
          if (digit.digit_count !== exp_digit.digit_count) begin
            $display("%0t: digit_count mismatch, expected %0d actual %0d", $time,
                     exp_digit.digit_count, digit.digit_count);
            error_count++;
          end
        end
      end
    end
  end

  task automatic test_directed_extremes();
    send_request(make_req('0, 6'd10, "a"));
    send_request(make_req(64'd1, 6'd2, "a"));
    send_request(make_req(ALL_ONES, 6'd2, "a"));
    send_request(make_req(ALL_ONES, 6'd36, "A"));
    send_request(make_req(ALL_ONES, 6'd16, "a"));
    send_request(make_req(ALL_ONES, 6'd10, "a"));
    send_request(make_req(ALL_ONES, 6'd3, "a"));
    send_request(make_req(64'd10_000_000_000_000_000_000, 6'd10, "a"));
    send_request(make_req(64'h8000_0000_0000_0000, 6'd2, "a"));
    send_request(make_req(64'h8000_0000_0000_0000, 6'd8, "a"));
    send_request(make_req(64'd36, 6'd36, "a"));
    // clamp radix below two and above 36
    send_request(make_req(64'd5, 6'd0, "a"));
    send_request(make_req(64'd255, 6'd1, "a"));
    send_request(make_req(64'd1295, 6'd37, "a"));
    send_request(make_req(ALL_ONES, 6'd63, "a"));
    // wrap the letter code past 255 and start the letters at code zero
    send_request(make_req(64'd35, 6'd36, 8'hFF));
    send_request(make_req(64'd1295, 6'd36, 8'hF7));
    send_request(make_req(64'd10, 6'd11, 8'h00));
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(1, 4)) send_request(random_req());
      wait_drained();
    end
  endtask

  task automatic test_random_mixed();
    repeat (300) send_request(random_req());
  endtask

  task automatic test_random_no_idle();
    idle_enable = 1'b0;
    repeat (90) send_request(random_req());
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_drain_pause();
    test_random_mixed();
    test_random_no_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("unsigned_to_radix_digits_tb: PASS");
    end else begin
      $display("unsigned_to_radix_digits_tb: FAIL");
    end
    $finish;
  end

endmodule
